// ----- rtl/tmwf_pkg.sv -----
package tmwf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int MEAN_W   = 20;
    localparam int FRAC_W   = 4;
    localparam int AXES     = 3;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [MEAN_W-1:0]   mean_t;

    // per-axis view of the sorted chain
    typedef struct packed {
        logic    near_full;
        sample_t lo;
        sample_t hi;
        sample_t oldest;
    } ends_t;

endpackage

// ----- rtl/trimmed_mean_window_filter_top.sv -----
// after its sample is accepted, a result goes via t_reg, prod_reg, mean_reg to mean_valid
// one sample per cycle while sample_stall is low, set by the sorted cell chain per axis
// the first WINDOW-1 samples after reset fill the window and give no result
// up to three results plus the output beat are buffered before sample_stall rises
// reset: asynchronous active-low, empties the window, the running sums and all stages
module trimmed_mean_window_filter_top
    import tmwf_pkg::*;
#(
    parameter int WINDOW = 12
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    sample_valid,
    output logic    sample_stall,
    input  sample_t x_sample,
    input  sample_t y_sample,
    input  sample_t z_sample,
    output logic    mean_valid,
    input  logic    mean_stall,
    output mean_t   x_mean,
    output mean_t   y_mean,
    output mean_t   z_mean
);

    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
    localparam int T_W    = SUM_W + 1;
    localparam int MAG_W  = SUM_W;
    localparam int N_W    = MAG_W + FRAC_W;
    localparam int DIV    = WINDOW - 2;
    localparam int K_SH   = N_W + $clog2(DIV);
    localparam int M_W    = K_SH + 1;
    localparam int PROD_W = N_W + M_W;
    localparam longint unsigned M_VAL =
        ((longint'(1) << K_SH) + longint'(DIV) - 1) / longint'(DIV);

    sample_t din [AXES];
    ends_t   ends [AXES];

    logic accept;
    logic en_s2;
    logic en_s3;
    logic en_out;
    logic en_s1;

    logic s1_vld_reg;
    logic s1_vld_next;
    logic s2_vld_reg;
    logic s2_vld_next;
    logic s3_vld_reg;
    logic s3_vld_next;
    logic out_vld_reg;
    logic out_vld_next;

    logic signed [SUM_W-1:0] sum_reg  [AXES];
    logic signed [SUM_W-1:0] sum_next [AXES];
    logic signed [T_W-1:0]   t_reg    [AXES];
    logic signed [T_W-1:0]   t_next   [AXES];
    logic [PROD_W-1:0]       prod_reg [AXES];
    logic [PROD_W-1:0]       prod_next[AXES];
    logic                    neg_reg  [AXES];
    logic                    neg_next [AXES];
    mean_t                   mean_reg [AXES];
    mean_t                   mean_next[AXES];

    assign din[0] = x_sample;
    assign din[1] = y_sample;
    assign din[2] = z_sample;

    assign en_out = !out_vld_reg || !mean_stall;
    assign en_s3  = !s3_vld_reg || en_out;
    assign en_s2  = !s2_vld_reg || en_s3;
    assign en_s1  = !s1_vld_reg || en_s2;

    assign sample_stall = !en_s1;
    assign accept       = sample_valid && en_s1;

    for (genvar a = 0; a < AXES; a++)
    begin : g_axis
        tmwf_chain #(
            .WINDOW (WINDOW)
        ) u_chain (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (accept),
            .din   (din[a]),
            .ends  (ends[a])
        );
    end

    always_comb
    begin
        s1_vld_next  = s1_vld_reg;
        s2_vld_next  = s2_vld_reg;
        s3_vld_next  = s3_vld_reg;
        out_vld_next = out_vld_reg;

        priority if (accept)
        begin
            s1_vld_next = ends[0].near_full;
        end
        else if (en_s2)
        begin
            s1_vld_next = 1'b0;
        end

        if (en_s2)
        begin
            s2_vld_next = s1_vld_reg;
        end
        if (en_s3)
        begin
            s3_vld_next = s2_vld_reg;
        end
        if (en_out)
        begin
            out_vld_next = s3_vld_reg;
        end
    end

    always_comb
    begin
        logic [T_W-1:0]      mag_full;
        logic [MAG_W-1:0]    mag;
        logic [N_W-1:0]      n;
        logic [MEAN_W-1:0]   q;

        for (int a = 0; a < AXES; a++)
        begin
            sum_next[a] = SUM_W'(sum_reg[a] + SUM_W'(din[a]) - SUM_W'(ends[a].oldest));

            t_next[a] = T_W'(sum_reg[a]) - T_W'(ends[a].lo) - T_W'(ends[a].hi);

            neg_next[a]  = t_reg[a][T_W-1];
            mag_full     = neg_next[a] ? T_W'(-t_reg[a]) : T_W'(t_reg[a]);
            mag          = mag_full[MAG_W-1:0];
            n            = {mag, {FRAC_W{1'b0}}};
            prod_next[a] = PROD_W'(n) * PROD_W'(M_VAL);

            q            = prod_reg[a][K_SH +: MEAN_W];
            mean_next[a] = neg_reg[a] ? mean_t'(-q) : mean_t'(q);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int a = 0; a < AXES; a++)
            begin
                sum_reg[a] <= '0;
            end
        end
        else
        begin
            s1_vld_reg  <= s1_vld_next;
            s2_vld_reg  <= s2_vld_next;
            s3_vld_reg  <= s3_vld_next;
            out_vld_reg <= out_vld_next;
            if (accept)
            begin
                for (int a = 0; a < AXES; a++)
                begin
                    sum_reg[a] <= sum_next[a];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < AXES; a++)
        begin
            if (en_s2)
            begin
                t_reg[a] <= t_next[a];
            end
            if (en_s3)
            begin
                prod_reg[a] <= prod_next[a];
                neg_reg[a]  <= neg_next[a];
            end
            if (en_out)
            begin
                mean_reg[a] <= mean_next[a];
            end
        end
    end

    assign mean_valid = out_vld_reg;
    assign x_mean     = mean_reg[0];
    assign y_mean     = mean_reg[1];
    assign z_mean     = mean_reg[2];

endmodule

// ----- rtl/tmwf_cell.sv -----
module tmwf_cell
    import tmwf_pkg::*;
#(
    parameter int WINDOW = 12,
    parameter int AGE_W  = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift,
    input  logic             full,
    input  sample_t          din,
    input  logic             left_vld,
    input  logic [AGE_W-1:0] left_age,
    input  sample_t          left_val,
    input  logic             left_below,
    input  logic             right_vld,
    input  logic [AGE_W-1:0] right_age,
    input  sample_t          right_val,
    input  logic             right_below,
    input  logic             del_above,
    output logic             vld,
    output logic [AGE_W-1:0] age,
    output sample_t          val,
    output logic             below,
    output logic             del,
    output logic             del_at_above
);

    logic             vld_reg;
    logic             vld_next;
    logic [AGE_W-1:0] age_reg;
    logic [AGE_W-1:0] age_next;
    sample_t          val_reg;
    sample_t          val_next;

    logic             cur_vld;
    logic [AGE_W-1:0] cur_age;
    sample_t          cur_val;
    logic             cur_below;
    logic             prev_vld;
    logic [AGE_W-1:0] prev_age;
    sample_t          prev_val;
    logic             prev_below;

    assign below        = vld_reg && (val_reg < din);
    assign del          = full && vld_reg && (age_reg == AGE_W'(WINDOW - 1));
    assign del_at_above = del || del_above;

    // view after dropping the oldest entry when the window is full, then insertion of the new sample
    always_comb
    begin
        if (del_above || !full)
        begin
            cur_vld   = vld_reg;
            cur_age   = age_reg;
            cur_val   = val_reg;
            cur_below = below;
        end
        else
        begin
            cur_vld   = right_vld;
            cur_age   = right_age;
            cur_val   = right_val;
            cur_below = right_below;
        end

        if (del_at_above || !full)
        begin
            prev_vld   = left_vld;
            prev_age   = left_age;
            prev_val   = left_val;
            prev_below = left_below;
        end
        else
        begin
            prev_vld   = vld_reg;
            prev_age   = age_reg;
            prev_val   = val_reg;
            prev_below = below;
        end

        priority if (cur_below)
        begin
            vld_next = cur_vld;
            age_next = cur_age + AGE_W'(1);
            val_next = cur_val;
        end
        else if (prev_below)
        begin
            vld_next = 1'b1;
            age_next = '0;
            val_next = din;
        end
        else
        begin
            vld_next = prev_vld;
            age_next = prev_age + AGE_W'(1);
            val_next = prev_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (shift)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            age_reg <= age_next;
            val_reg <= val_next;
        end
    end

    assign vld = vld_reg;
    assign age = age_reg;
    assign val = val_reg;

endmodule

// ----- rtl/tmwf_chain.sv -----
module tmwf_chain
    import tmwf_pkg::*;
#(
    parameter int WINDOW = 12
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    shift,
    input  sample_t din,
    output ends_t   ends
);

    localparam int AGE_W = $clog2(WINDOW);

    // padded by one slot on each side, cell i sits at index i+1
    logic             pad_vld   [WINDOW+2];
    logic [AGE_W-1:0] pad_age   [WINDOW+2];
    sample_t          pad_val   [WINDOW+2];
    logic             pad_below [WINDOW+2];
    logic             del_w     [WINDOW];
    logic             dab_w     [WINDOW+1];
    logic             full;
    sample_t          oldest;

    assign pad_vld[0]          = 1'b0;
    assign pad_age[0]          = '0;
    assign pad_val[0]          = '0;
    assign pad_below[0]        = 1'b1;
    assign pad_vld[WINDOW+1]   = 1'b0;
    assign pad_age[WINDOW+1]   = '0;
    assign pad_val[WINDOW+1]   = '0;
    assign pad_below[WINDOW+1] = 1'b0;
    assign dab_w[WINDOW]       = 1'b0;

    assign full = pad_vld[WINDOW];

    for (genvar i = 0; i < WINDOW; i++)
    begin : g_cell
        tmwf_cell #(
            .WINDOW (WINDOW),
            .AGE_W  (AGE_W)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .shift        (shift),
            .full         (full),
            .din          (din),
            .left_vld     (pad_vld[i]),
            .left_age     (pad_age[i]),
            .left_val     (pad_val[i]),
            .left_below   (pad_below[i]),
            .right_vld    (pad_vld[i+2]),
            .right_age    (pad_age[i+2]),
            .right_val    (pad_val[i+2]),
            .right_below  (pad_below[i+2]),
            .del_above    (dab_w[i+1]),
            .vld          (pad_vld[i+1]),
            .age          (pad_age[i+1]),
            .val          (pad_val[i+1]),
            .below        (pad_below[i+1]),
            .del          (del_w[i]),
            .del_at_above (dab_w[i])
        );
    end

    always_comb
    begin
        oldest = '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            oldest = oldest | (del_w[i] ? pad_val[i+1] : sample_t'(0));
        end
    end

    assign ends.near_full = pad_vld[WINDOW-1];
    assign ends.lo        = pad_val[1];
    assign ends.hi        = pad_val[WINDOW];
    assign ends.oldest    = oldest;

endmodule

// ----- rtl/tmwf_checker.sv -----
module tmwf_checker
    import tmwf_pkg::*;
#(
    parameter int WINDOW = 12
)
(
    input logic  clk,
    input logic  rst_n,
    input logic  sample_valid,
    input logic  sample_stall,
    input logic  mean_valid,
    input logic  mean_stall,
    input mean_t x_mean,
    input mean_t y_mean,
    input mean_t z_mean
);

    localparam int FILL_W = $clog2(WINDOW);

    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [2:0]        pend_reg;
    logic [2:0]        pend_next;
    logic              in_beat;
    logic              out_beat;
    logic              emits;

    assign in_beat  = sample_valid && !sample_stall;
    assign out_beat = mean_valid && !mean_stall;
    assign emits    = in_beat && (fill_reg == FILL_W'(WINDOW - 1));

    always_comb
    begin
        fill_next = fill_reg;
        if (in_beat && (fill_reg != FILL_W'(WINDOW - 1)))
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        pend_next = pend_reg + {2'b00, emits} - {2'b00, out_beat};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            pend_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            pend_reg <= pend_next;
        end
    end

    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (mean_valid && mean_stall))
        else $error("input stalled while the output side is free");

    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        mean_valid |-> (pend_reg != 3'd0))
        else $error("result beat without a matching full-window sample");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 3'd4)
        else $error("more results in flight than the pipeline holds");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (mean_valid && mean_stall) |=> mean_valid)
        else $error("mean_valid dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (mean_valid && mean_stall) |=> ($stable(x_mean) && $stable(y_mean) && $stable(z_mean)))
        else $error("result payload changed while stalled");

endmodule

bind trimmed_mean_window_filter_top tmwf_checker #(.WINDOW(WINDOW)) u_tmwf_checker (.*);
